// File: rtl/core/dogu_pkg.sv
package dogu_pkg;

	localparam int GRID_SIDE_DEF = 256;
	localparam int SLOTS = 5;
	localparam int VW = 16;
	// Holds sixteen full-scale tile values with sign.
	localparam int ACCW = 20;

	localparam logic signed [VW-1:0] Q_ONE = 16'sd16384;
	localparam logic signed [VW-1:0] FACING_ZERO_LIMIT = 16'sd163;

	localparam logic [14:0] THR_RESET = 15'd11469;
	localparam logic signed [VW-1:0] SEEN_RESET = 16'sd1638;

	localparam logic [1:0] CFG_THR = 2'd0;
	localparam logic [1:0] CFG_SEEN = 2'd1;
	localparam logic [1:0] CFG_MODE = 2'd2;

	localparam logic [2:0] SLOT_OCC = 3'd4;
	localparam logic [2:0] FACING_LAST = 3'd3;

	localparam logic [3:0] NBR_FIRST = 4'd1;
	localparam logic [3:0] NBR_LAST = 4'd8;

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_SEEN,
		ACT_READ,
		ACT_LAND
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_NBR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic wr;
		logic [SLOTS-1:0][VW-1:0] val;
	} tile_t;

	typedef struct packed {
		logic signed [2:0] dx;
		logic signed [2:0] dy;
	} offset_t;

	// Neighbour visiting order: the column pair at one and two rows away,
	// then the row pair at one and two columns away.
	function automatic offset_t nbr_offset(input logic [3:0] k);
		offset_t o;
		unique case (k)
			4'd1: o = '{dx: 3'sd0, dy: -3'sd1};
			4'd2: o = '{dx: 3'sd0, dy: 3'sd1};
			4'd3: o = '{dx: 3'sd0, dy: -3'sd2};
			4'd4: o = '{dx: 3'sd0, dy: 3'sd2};
			4'd5: o = '{dx: -3'sd1, dy: 3'sd0};
			4'd6: o = '{dx: 3'sd1, dy: 3'sd0};
			4'd7: o = '{dx: -3'sd2, dy: 3'sd0};
			4'd8: o = '{dx: 3'sd2, dy: 3'sd0};
			default: o = '{dx: 3'sd0, dy: 3'sd0};
		endcase
		return o;
	endfunction

	// Direct neighbours carry twice the weight of those two tiles away.
	function automatic logic nbr_double(input logic [3:0] k);
		logic d;
		case (k) inside
			4'd1, 4'd2, 4'd5, 4'd6: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/core/directional_occupancy_grid_update.sv
// Directional occupancy grid: a GRID_SIDE x GRID_SIDE tile memory, five Q1.14 values per tile,
// updated and queried one item at a time. After reset a clearing pass writes every tile once, and
// no item is accepted until it ends; configuration writes are taken at any time. An add, seen,
// read or fallback landmark item passes through the registered memory read, then a step that
// registers the result and writes an on-grid add or seen update back through the shared adder.
// A neighbour-mode landmark item goes straight from the centre read to its final step when the
// centre tile alone passes; else the eight neighbour tiles are first read one per cycle through
// the single read port and summed by the same adder. An earlier result that is not yet taken
// holds the block in its final step; the next item is accepted while the result waits.
module directional_occupancy_grid_update
	import dogu_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic signed [7:0]     tile_x,
	input  logic signed [7:0]     tile_y,
	input  logic [2:0]            facing,
	input  logic signed [VW-1:0]  delta,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [VW-1:0]  value,
	output logic                  is_landmark,
	output logic                  off_grid,
	output logic signed [7:0]     min_x,
	output logic signed [7:0]     max_x,
	output logic signed [7:0]     min_y,
	output logic signed [7:0]     max_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam int AW = $clog2(GRID_SIDE);
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int ADW = $clog2(DEPTH);
	localparam int CW = ((AW > 8) ? AW : 8) + 2;
	localparam int HALF = GRID_SIDE / 2;

	typedef struct packed {
		logic on;
		logic [ADW-1:0] addr;
	} loc_t;

	function automatic loc_t locate(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] r;
		loc_t l;
		c = x + $signed(CW'(HALF));
		r = y + $signed(CW'(HALF));
		l.on = (c >= 0) && (c < $signed(CW'(GRID_SIDE))) &&
			(r >= 0) && (r < $signed(CW'(GRID_SIDE)));
		l.addr = ADW'(c[AW-1:0]) * ADW'(GRID_SIDE) + ADW'(r[AW-1:0]);
		return l;
	endfunction

	state_t state_q, state_d;

	// Tile memory and its registered read.
	tile_t tile_store_q [DEPTH];
	tile_t rd_tile_q;
	logic rd_on_q;
	logic rd_en, mem_we;
	loc_t rd_loc;
	logic [ADW-1:0] wr_addr;
	tile_t wr_tile;
	logic [ADW-1:0] clr_q;

	// Configuration.
	logic [14:0] thr_q;
	logic signed [VW-1:0] seen_q;
	logic nmode_q;

	// Item held while it is worked on.
	action_t act_q;
	logic signed [7:0] x_q, y_q;
	logic [2:0] slot_q;
	logic signed [VW-1:0] delta_q;
	logic on_q;
	logic [ADW-1:0] addr_q;

	// Neighbour walk.
	logic [3:0] cnt_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [VW-1:0] cval_q;
	logic mark_q;

	// Bounds and result register.
	logic signed [7:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic signed [7:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d;
	logic out_valid_q;
	logic signed [VW-1:0] value_q;
	logic mark_out_q, off_q;

	logic out_free, out_load, commit, nbr_path;
	logic [3:0] nb_k;
	offset_t nb_off;
	logic signed [VW-1:0] cur_v, cval_v, d_v, clamp_v, rv;
	logic signed [VW:0] thr_s;
	logic signed [ACCW-1:0] alu_a, alu_b, alu_sum, thr4;
	logic pass, near_zero, fb_mark, center_hit, upd;
	logic signed [VW-1:0] value_d;
	logic mark_d;

	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign nbr_path = (act_q == ACT_LAND) && nmode_q;
	assign upd = ((act_q == ACT_ADD) || (act_q == ACT_SEEN)) && on_q;

	// Shared datapath: one adder serves the delta update and the neighbour sum.
	always_comb begin
		thr_s = $signed({2'b00, thr_q});
		thr4 = $signed({3'b000, thr_q, 2'b00});
		cur_v = $signed(rd_tile_q.val[slot_q]);
		cval_v = on_q ? cur_v : '0;
		d_v = (act_q == ACT_ADD) ? delta_q : seen_q;
		pass = ((17'(cur_v) < thr_s) && (17'(cur_v) > -thr_s)) ||
			((cur_v > 0) && (d_v > 0)) || ((cur_v < 0) && (d_v < 0));
		rv = $signed(rd_tile_q.val[slot_q]);
		if (state_q == ST_NBR) begin
			alu_a = acc_q;
			if (!rd_on_q) begin
				alu_b = '0;
			end else if (nbr_double(cnt_q)) begin
				alu_b = ACCW'(rv) <<< 1;
			end else begin
				alu_b = ACCW'(rv);
			end
		end else begin
			alu_a = ACCW'(cur_v);
			alu_b = pass ? ACCW'(d_v) : '0;
		end
		alu_sum = alu_a + alu_b;
		if (alu_sum > ACCW'(Q_ONE)) begin
			clamp_v = Q_ONE;
		end else if (alu_sum < -ACCW'(Q_ONE)) begin
			clamp_v = -Q_ONE;
		end else begin
			clamp_v = $signed(alu_sum[VW-1:0]);
		end
		near_zero = 1'b1;
		for (int i = 0; i <= int'(FACING_LAST); i++) begin
			if ($signed(rd_tile_q.val[i]) > FACING_ZERO_LIMIT) begin
				near_zero = 1'b0;
			end
		end
		fb_mark = on_q && rd_tile_q.wr && ((17'(cur_v) >= thr_s) ||
			(near_zero && (17'($signed(rd_tile_q.val[SLOT_OCC])) >= thr_s)));
		center_hit = 17'(cval_v) >= thr_s;
	end

	// Bounds after the current step.
	always_comb begin
		lo_x_d = lo_x_q;
		hi_x_d = hi_x_q;
		lo_y_d = lo_y_q;
		hi_y_d = hi_y_q;
		if ((state_q == ST_EXEC) && upd) begin
			if (x_q < lo_x_q) lo_x_d = x_q;
			if (x_q > hi_x_q) hi_x_d = x_q;
			if (y_q < lo_y_q) lo_y_d = y_q;
			if (y_q > hi_y_q) hi_y_d = y_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (nbr_path) begin
					state_d = center_hit ? ST_FIN : ST_NBR;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_NBR: begin
				if (cnt_q == NBR_LAST) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		rd_en = 1'b0;
		mem_we = 1'b0;
		out_load = 1'b0;
		commit = 1'b0;
		wr_addr = addr_q;
		wr_tile = rd_tile_q;
		wr_tile.wr = 1'b1;
		wr_tile.val[slot_q] = clamp_v;
		nb_k = (state_q == ST_EXEC) ? NBR_FIRST : cnt_q + 4'd1;
		nb_off = nbr_offset(nb_k);
		rd_loc = locate(CW'(x_q) + CW'($signed(nb_off.dx)), CW'(y_q) + CW'($signed(nb_off.dy)));
		value_d = cval_v;
		mark_d = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				wr_addr = clr_q;
				wr_tile = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en = in_valid;
				rd_loc = locate(CW'(tile_x), CW'(tile_y));
			end
			ST_EXEC: begin
				if (nbr_path) begin
					rd_en = !center_hit;
				end else begin
					out_load = out_free;
					commit = out_free;
					mem_we = upd && out_free;
					if (act_q == ACT_ADD || act_q == ACT_SEEN) begin
						value_d = on_q ? clamp_v : '0;
					end
					mark_d = (act_q == ACT_LAND) && fb_mark;
				end
			end
			ST_NBR: begin
				rd_en = cnt_q != NBR_LAST;
			end
			ST_FIN: begin
				out_load = out_free;
				value_d = cval_q;
				mark_d = mark_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) tile_store_q[wr_addr] <= wr_tile;
		if (rd_en) begin
			rd_tile_q <= tile_store_q[rd_loc.addr];
			rd_on_q <= rd_loc.on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			lo_x_q <= '0;
			hi_x_q <= '0;
			lo_y_q <= '0;
			hi_y_q <= '0;
			thr_q <= THR_RESET;
			seen_q <= SEEN_RESET;
			nmode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				lo_x_q <= lo_x_d;
				hi_x_q <= hi_x_d;
				lo_y_q <= lo_y_d;
				hi_y_q <= hi_y_d;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_THR: thr_q <= cfg_data[14:0];
					CFG_SEEN: seen_q <= $signed(cfg_data);
					CFG_MODE: nmode_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_q <= action_t'(action);
			x_q <= tile_x;
			y_q <= tile_y;
			slot_q <= (facing > FACING_LAST) ? SLOT_OCC : facing;
			delta_q <= delta;
			on_q <= rd_loc.on;
			addr_q <= rd_loc.addr;
		end
		if (state_q == ST_EXEC && nbr_path) begin
			cval_q <= cval_v;
			acc_q <= ACCW'(cval_v) <<< 2;
			cnt_q <= NBR_FIRST;
			mark_q <= center_hit;
		end
		if (state_q == ST_NBR) begin
			acc_q <= alu_sum;
			cnt_q <= cnt_q + 4'd1;
			mark_q <= alu_sum >= thr4;
		end
		if (out_load) begin
			value_q <= value_d;
			mark_out_q <= mark_d;
			off_q <= !on_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign is_landmark = mark_out_q;
	assign off_grid = off_q;
	assign min_x = lo_x_q;
	assign max_x = hi_x_q;
	assign min_y = lo_y_q;
	assign max_y = hi_y_q;

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the previous one is still at work");

	ap_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_x_q <= hi_x_q) && (lo_y_q <= hi_y_q))
		else $error("bounds out of order");

	ap_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR) ||
			((state_q == ST_EXEC) && on_q && ((act_q == ACT_ADD) || (act_q == ACT_SEEN))))
		else $error("tile memory written outside clearing or an on-grid update");

	ap_nbr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NBR) |-> (cnt_q >= NBR_FIRST) && (cnt_q <= NBR_LAST))
		else $error("neighbour counter out of range");

endmodule
